### sv/epdm_pkg.sv
package epdm_pkg;

	// Default build values
	localparam int NUM_CHANNELS_DEF = 3;
	localparam int COUNTER_BITS_DEF = 32;

	// Fixed field widths
	localparam int CH_FIELD_W = 2;
	localparam int DATA_W     = 32;
	localparam int TICKS_W    = 10;
	localparam int DIST_W     = 27;

	// Arithmetic constants
	localparam logic [TICKS_W-1:0] TICKS_RESET = 10'd84;
	localparam logic [TICKS_W-1:0] CM_DIVISOR  = 10'd58;

	// Input transaction: one edge capture event
	typedef struct packed {
		logic [CH_FIELD_W-1:0] channel;
		logic [DATA_W-1:0]     capture_value;
	} in_item_t;

	// Output transaction: one completed measurement
	typedef struct packed {
		logic [CH_FIELD_W-1:0] sensor;
		logic [DATA_W-1:0]     echo_us;
		logic [DIST_W-1:0]     distance_cm;
	} out_item_t;

endpackage

### sv/epdm_div.sv
module epdm_div
	import epdm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DATA_W-1:0]  dividend,
	input  logic [TICKS_W-1:0] divisor,
	output logic               done,
	output logic [DATA_W-1:0]  quotient
);

	localparam int CNT_W = $clog2(DATA_W);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [DATA_W-1:0]  dq_q;
	logic [TICKS_W-1:0] rem_q;
	logic [TICKS_W-1:0] div_q;

	logic [TICKS_W:0]   trial;
	logic               ge;
	logic [TICKS_W:0]   diff;

	// One restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		trial = {rem_q, dq_q[DATA_W-1]};
		ge    = (trial >= {1'b0, div_q});
		diff  = trial - {1'b0, div_q};
	end

	// Control: step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DATA_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath: quotient bits shift in where dividend bits shift out
	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			dq_q  <= {dq_q[DATA_W-2:0], ge};
			rem_q <= ge ? diff[TICKS_W-1:0] : trial[TICKS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

### sv/epdm_edge_store.sv
module epdm_edge_store
	import epdm_pkg::*;
#(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
	parameter int COUNTER_BITS = COUNTER_BITS_DEF,
	parameter int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    capture,
	input  logic [CH_W-1:0]         ch_idx,
	input  logic [COUNTER_BITS-1:0] stamp,
	output logic                    second_edge,
	output logic [COUNTER_BITS-1:0] elapsed
);

	logic [NUM_CHANNELS-1:0] awaiting_q;
	logic [COUNTER_BITS-1:0] first_q [NUM_CHANNELS];

	// Lookup for the addressed channel; difference wraps modulo counter width
	assign second_edge = awaiting_q[ch_idx];
	assign elapsed     = stamp - first_q[ch_idx];

	// An opening edge stores its stamp, a closing edge rearms the channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				first_q[i] <= '0;
			end
		end else if (capture) begin
			awaiting_q[ch_idx] <= ~awaiting_q[ch_idx];
			if (!awaiting_q[ch_idx]) begin
				first_q[ch_idx] <= stamp;
			end
		end
	end

endmodule

### sv/echo_pulse_distance_meter.sv
// Echo pulse distance meter: a first edge per channel only stores its stamp.
// A closing edge runs two 32-step divisions on one shared restoring divider
// (ticks / ticks_per_us, then / 58), and the result goes into the output register.
// All input stalls until that result is registered; the divider makes one bit per cycle.
// Reset (arst_n low, asynchronous) clears all channels to "waiting for first edge",
// zeroes stored stamps, empties the output register and sets ticks_per_us to 84.
module echo_pulse_distance_meter
	import epdm_pkg::*;
#(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
	parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [TICKS_W-1:0] cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  in_item_t           in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output out_item_t          out_data
);

	localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV1 = 2'd1;
	localparam logic [1:0] ST_DIV2 = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]              state_q;
	logic [TICKS_W-1:0]      ticks_q;
	logic [CH_FIELD_W-1:0]   sensor_q;
	logic [DATA_W-1:0]       echo_q;
	logic [DIST_W-1:0]       dist_q;
	logic                    out_valid_q;
	out_item_t               out_q;

	logic                    accept;
	logic                    in_range;
	logic [CH_W-1:0]         ch_idx;
	logic [COUNTER_BITS-1:0] stamp;
	logic                    second_edge;
	logic [COUNTER_BITS-1:0] elapsed;
	logic                    capture;
	logic                    out_free;

	logic                    div_start;
	logic [DATA_W-1:0]       div_dividend;
	logic [TICKS_W-1:0]      div_divisor;
	logic                    div_done;
	logic [DATA_W-1:0]       div_quot;

	// Input handshake and channel decode
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign in_range = (32'(in_data.channel) < NUM_CHANNELS);
	assign ch_idx   = CH_W'(in_data.channel);
	assign stamp    = in_data.capture_value[COUNTER_BITS-1:0];
	assign capture  = accept && in_range;
	assign out_free = !out_valid_q || !out_stall;

	epdm_edge_store #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.COUNTER_BITS (COUNTER_BITS),
		.CH_W         (CH_W)
	) u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.capture     (capture),
		.ch_idx      (ch_idx),
		.stamp       (stamp),
		.second_edge (second_edge),
		.elapsed     (elapsed)
	);

	// Divider operand select: first pass by ticks_per_us, second by 58
	always_comb begin
		div_start    = 1'b0;
		div_dividend = DATA_W'(elapsed);
		div_divisor  = ticks_q;
		if (state_q == ST_IDLE) begin
			div_start = capture && second_edge;
		end else if (state_q == ST_DIV1) begin
			div_start    = div_done;
			div_dividend = div_quot;
			div_divisor  = CM_DIVISOR;
		end
	end

	epdm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= TICKS_RESET;
		end else if (cfg_we) begin
			ticks_q <= cfg_wdata;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (capture && second_edge) begin
						state_q <= ST_DIV1;
					end
				end
				ST_DIV1: begin
					if (div_done) begin
						state_q <= ST_DIV2;
					end
				end
				ST_DIV2: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result capture and output register
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && capture && second_edge) begin
			sensor_q <= in_data.channel;
		end
		if (state_q == ST_DIV1 && div_done) begin
			echo_q <= div_quot;
		end
		if (state_q == ST_DIV2 && div_done) begin
			dist_q <= div_quot[DIST_W-1:0];
		end
		if (state_q == ST_DONE && out_free) begin
			out_q.sensor      <= sensor_q;
			out_q.echo_us     <= echo_q;
			out_q.distance_cm <= dist_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
